// ===== hdl/utf8cs_pkg.sv =====
// Package for the UTF-8 character splitter: error codes, decoder state and
// result types, and the byte classification constants.
// No dependencies.
package utf8cs_pkg;

  localparam int unsigned MaxChar   = 6;
  localparam int unsigned BufWidth  = 8 * MaxChar;

  localparam logic [7:0] LeadTwo    = 8'hc2;
  localparam logic [7:0] LeadThree  = 8'he0;
  localparam logic [7:0] LeadFour   = 8'hf0;
  localparam logic [7:0] LeadFive   = 8'hf8;
  localparam logic [7:0] LeadSix    = 8'hfc;
  localparam logic [7:0] LeadBad    = 8'hfe;
  localparam logic [7:0] ContMask   = 8'hc0;
  localparam logic [7:0] ContTag    = 8'h80;
  localparam logic [7:0] MinSecE0   = 8'ha0;
  localparam logic [7:0] MinSecF0   = 8'h90;
  localparam logic [7:0] MinSecF8   = 8'h88;
  localparam logic [7:0] MinSecFc   = 8'h84;

  typedef enum logic [2:0] {
    ErrNone     = 3'd0,
    ErrLead     = 3'd1,
    ErrCont     = 3'd2,
    ErrOverlong = 3'd3,
    ErrTrunc    = 3'd4
  } err_e;

  typedef struct packed {
    logic [2:0]          exp_len;
    logic [2:0]          count;
    logic [BufWidth-1:0] buffer;
    logic                halted;
  } state_t;

  typedef struct packed {
    logic                valid;
    logic [BufWidth-1:0] bytes;
    logic [2:0]          length;
    err_e                err;
  } result_t;

  // Sequence length opened by a lead byte; zero when the byte is no lead.
  function automatic logic [2:0] lead_length(logic [7:0] c);
    logic [2:0] n;
    if (c < ContTag)        n = 3'd1;
    else if (c < LeadTwo)   n = 3'd0;
    else if (c < LeadThree) n = 3'd2;
    else if (c < LeadFour)  n = 3'd3;
    else if (c < LeadFive)  n = 3'd4;
    else if (c < LeadSix)   n = 3'd5;
    else if (c < LeadBad)   n = 3'd6;
    else                    n = 3'd0;
    return n;
  endfunction

endpackage

// ===== hdl/utf8cs_decode.sv =====
// Next-state and result logic for one byte of the UTF-8 character splitter.
// Depends on utf8cs_pkg.
module utf8cs_decode (
  input  utf8cs_pkg::state_t  state_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output utf8cs_pkg::state_t  state_o,
  output utf8cs_pkg::result_t result_o
);

  logic [2:0]                      n_lead;
  logic [7:0]                      lead;
  logic                            overlong;
  logic [utf8cs_pkg::BufWidth-1:0] merged;
  logic [2:0]                      count_inc;
  utf8cs_pkg::state_t              nxt;
  utf8cs_pkg::result_t             res;

  assign n_lead    = utf8cs_pkg::lead_length(byte_i);
  assign lead      = state_i.buffer[7:0];
  assign count_inc = state_i.count + 3'd1;

  always_comb begin
    overlong = 1'b0;
    if (lead == utf8cs_pkg::LeadThree) overlong = byte_i < utf8cs_pkg::MinSecE0;
    if (lead == utf8cs_pkg::LeadFour)  overlong = byte_i < utf8cs_pkg::MinSecF0;
    if (lead == utf8cs_pkg::LeadFive)  overlong = byte_i < utf8cs_pkg::MinSecF8;
    if (lead == utf8cs_pkg::LeadSix)   overlong = byte_i < utf8cs_pkg::MinSecFc;
  end

  // The new byte lands in the lane given by the number already gathered.
  always_comb begin
    merged = state_i.buffer;
    for (int i = 1; i < utf8cs_pkg::MaxChar; i++) begin
      if (state_i.count == 3'(i)) merged[i*8 +: 8] = byte_i;
    end
  end

  always_comb begin
    nxt = state_i;
    res = '{valid: 1'b0, bytes: '0, length: 3'd0, err: utf8cs_pkg::ErrNone};
    if (!state_i.halted) begin
      if (state_i.exp_len == 3'd0) begin
        if (n_lead == 3'd0) begin
          res.err = utf8cs_pkg::ErrLead;
        end else if (n_lead == 3'd1) begin
          res.valid  = 1'b1;
          res.length = 3'd1;
          res.bytes  = {{(utf8cs_pkg::BufWidth-8){1'b0}}, byte_i};
        end else begin
          nxt.exp_len = n_lead;
          nxt.count   = 3'd1;
          nxt.buffer  = {{(utf8cs_pkg::BufWidth-8){1'b0}}, byte_i};
        end
      end else if ((byte_i & utf8cs_pkg::ContMask) != utf8cs_pkg::ContTag) begin
        res.err = utf8cs_pkg::ErrCont;
      end else if (state_i.count == 3'd1 && overlong) begin
        res.err = utf8cs_pkg::ErrOverlong;
      end else if (count_inc >= state_i.exp_len) begin
        res.valid   = 1'b1;
        res.length  = state_i.exp_len;
        res.bytes   = merged;
        nxt.exp_len = 3'd0;
        nxt.count   = 3'd0;
        nxt.buffer  = '0;
      end else begin
        nxt.buffer = merged;
        nxt.count  = count_inc;
      end

      if (res.err != utf8cs_pkg::ErrNone) begin
        nxt.halted  = 1'b1;
        nxt.exp_len = 3'd0;
        nxt.count   = 3'd0;
        nxt.buffer  = '0;
      end else if (last_i && nxt.exp_len != 3'd0) begin
        res.err = utf8cs_pkg::ErrTrunc;
      end
    end
    if (last_i) begin
      nxt = '{exp_len: 3'd0, count: 3'd0, buffer: '0, halted: 1'b0};
    end
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

// ===== hdl/utf8_character_splitter.sv =====
// Top level of the UTF-8 character splitter: input register, decoder state
// and output register on two stream channels.
// Depends on utf8cs_pkg and utf8cs_decode.
//
//   channel   direction  payload
//   s_axis    in         tdata = byte_in, tlast = last_byte
//   m_axis    out        tdata = char_valid, char_bytes, char_length,
//                        error_code; tlast = end_of_string
//
// One byte is accepted per cycle while m_axis does not stall; each byte yields one result
// transaction, registered first in the input register, then in the output register.
// The decoder state updates as a byte moves from the input register to the
// output register, so back-to-back bytes see each other's state.
// A stall on m_axis holds both registers; s_axis_tready_o drops once both are full.
// Reset clears the decoder state and both valid flags.
module utf8_character_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_in
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] char_valid, [48:1] char_bytes, [51:49] char_length,
  // [54:52] error_code, [55] zero
  output logic [55:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o    // end_of_string
);

  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic                in_last_q;
  logic                out_valid_q;
  utf8cs_pkg::result_t out_res_q;
  logic                out_last_q;
  utf8cs_pkg::state_t  state_q, state_d;
  utf8cs_pkg::result_t res_d;
  logic                advance;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;

  utf8cs_decode u_decode (
    .state_i  (state_q),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{exp_len: 3'd0, count: 3'd0, buffer: '0, halted: 1'b0};
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (advance) out_valid_q <= in_valid_q;
      if (advance && in_valid_q) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance && in_valid_q) begin
      out_res_q  <= res_d;
      out_last_q <= in_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_res_q.err, out_res_q.length,
                            out_res_q.bytes, out_res_q.valid};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== hdl/utf8cs_checker.sv =====
// Port-level checks for the UTF-8 character splitter, bound to its top level.
// Depends on utf8_character_splitter.
module utf8cs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [55:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // An emitted character has a length of one to six bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |->
      m_axis_tdata_o[51:49] != 3'd0 && m_axis_tdata_o[51:49] != 3'd7)
    else $error("character with bad length");

  // No character is emitted in the transaction that reports an error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[54:52] == 3'd0)
    else $error("character emitted together with an error");

  // Without a character, length and bytes are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |->
      m_axis_tdata_o[51:49] == 3'd0 && m_axis_tdata_o[48:1] == 48'd0)
    else $error("stale character payload");

endmodule

bind utf8_character_splitter utf8cs_checker u_utf8cs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
